>>> hdl/sphdp_pkg.sv
// Shared types, constants and the micro-program for the SPH density and pressure unit.
`timescale 1ns / 1ps

package sphdp_pkg;

	// Widths of the fixed point quantities
	localparam int unsigned POS_W   = 24;
	localparam int unsigned ABS_W   = POS_W + 1;
	localparam int unsigned MASS_W  = 24;
	localparam int unsigned H2_W    = 24;
	localparam int unsigned COEF_W  = 32;
	localparam int unsigned REST_W  = 24;
	localparam int unsigned GAIN_W  = 24;
	localparam int unsigned DENS_W  = 24;
	localparam int unsigned PRES_W  = 32;
	localparam int unsigned SUM_W   = 48;
	localparam int unsigned HQ_W    = H2_W + 16;
	localparam int unsigned R2_W    = 2 * ABS_W;
	localparam int unsigned Q2_W    = 48;
	localparam int unsigned Q3_W    = 56;
	localparam int unsigned MC_W    = MASS_W + COEF_W;
	localparam int unsigned CFG_W   = 32;

	// Shared multiplier: operands are taken apart into two digits
	localparam int unsigned DIG_W   = 28;
	localparam int unsigned OPV_W   = 2 * DIG_W;
	localparam int unsigned PROD_W  = 2 * DIG_W;
	localparam int unsigned ACC_W   = 2 * OPV_W;

	// Neighbour limit per centre particle
	localparam int unsigned MAX_NEIGHBORS = 4096;
	localparam int unsigned CNT_W   = $clog2(MAX_NEIGHBORS + 1);

	// Micro-program counter and entry points
	localparam int unsigned PC_W    = 5;
	localparam logic [PC_W-1:0] PC_KERNEL   = PC_W'(8);
	localparam logic [PC_W-1:0] PC_TERM     = PC_W'(24);
	localparam logic [PC_W-1:0] PC_SELF     = PC_W'(25);
	localparam logic [PC_W-1:0] PC_SELF_END = PC_W'(26);
	localparam logic [PC_W-1:0] PC_DENS     = PC_W'(27);
	localparam logic [PC_W-1:0] PC_LAST     = PC_W'(31);

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_MASS = 3'd0,
		CFG_H2   = 3'd1,
		CFG_COEF = 3'd2,
		CFG_REST = 3'd3,
		CFG_GAIN = 3'd4
	} cfg_idx_t;

	// Multiplier operand sources
	typedef enum logic [3:0] {
		OP_ZERO,
		OP_PM,
		OP_KC,
		OP_AX,
		OP_AY,
		OP_AZ,
		OP_Q,
		OP_Q2,
		OP_Q3,
		OP_MC,
		OP_DIFF,
		OP_PG
	} opnd_t;

	// Second-stage actions of a micro-op
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_MCLR,
		ACT_MACC,
		ACT_ST_MC,
		ACT_ST_R2,
		ACT_ST_Q2,
		ACT_ST_Q3,
		ACT_ST_TERM,
		ACT_ST_SELF,
		ACT_ST_DENS,
		ACT_ST_PRES
	} act_t;

	typedef struct packed {
		opnd_t      a_sel;
		logic       a_dig;
		opnd_t      b_sel;
		logic       b_dig;
		act_t       act;
		logic [1:0] sh;
	} uop_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic publish;
		uop_t uop;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;
	} dp_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PUBLISH
	} ctrl_state_t;

	function automatic uop_t mk_uop(opnd_t a, logic ad, opnd_t b, logic bd, act_t act,
		logic [1:0] sh);
		uop_t u;
		u.a_sel = a;
		u.a_dig = ad;
		u.b_sel = b;
		u.b_dig = bd;
		u.act   = act;
		u.sh    = sh;
		return u;
	endfunction

	localparam uop_t UOP_NOP = '{a_sel: OP_ZERO, a_dig: 1'b0, b_sel: OP_ZERO, b_dig: 1'b0,
		act: ACT_NOP, sh: 2'd0};

	// Micro-program: mass times coefficient, squared distance, then the kernel
	// (q^2, q^3, times mc), self term entry, density and pressure.
	function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
		uop_t u;
		u = UOP_NOP;
		unique case (pc)
			5'd0:  u = mk_uop(OP_PM, 1'b0, OP_KC, 1'b0, ACT_MCLR, 2'd0);
			5'd1:  u = mk_uop(OP_PM, 1'b0, OP_KC, 1'b1, ACT_MACC, 2'd1);
			5'd2:  u = mk_uop(OP_ZERO, 1'b0, OP_ZERO, 1'b0, ACT_ST_MC, 2'd0);
			5'd3:  u = mk_uop(OP_AX, 1'b0, OP_AX, 1'b0, ACT_MCLR, 2'd0);
			5'd4:  u = mk_uop(OP_AY, 1'b0, OP_AY, 1'b0, ACT_MACC, 2'd0);
			5'd5:  u = mk_uop(OP_AZ, 1'b0, OP_AZ, 1'b0, ACT_MACC, 2'd0);
			5'd6:  u = mk_uop(OP_ZERO, 1'b0, OP_ZERO, 1'b0, ACT_ST_R2, 2'd0);
			5'd8:  u = mk_uop(OP_Q, 1'b0, OP_Q, 1'b0, ACT_MCLR, 2'd0);
			5'd9:  u = mk_uop(OP_Q, 1'b0, OP_Q, 1'b1, ACT_MACC, 2'd1);
			5'd10: u = mk_uop(OP_Q, 1'b1, OP_Q, 1'b0, ACT_MACC, 2'd1);
			5'd11: u = mk_uop(OP_Q, 1'b1, OP_Q, 1'b1, ACT_MACC, 2'd2);
			5'd12: u = mk_uop(OP_ZERO, 1'b0, OP_ZERO, 1'b0, ACT_ST_Q2, 2'd0);
			5'd14: u = mk_uop(OP_Q2, 1'b0, OP_Q, 1'b0, ACT_MCLR, 2'd0);
			5'd15: u = mk_uop(OP_Q2, 1'b0, OP_Q, 1'b1, ACT_MACC, 2'd1);
			5'd16: u = mk_uop(OP_Q2, 1'b1, OP_Q, 1'b0, ACT_MACC, 2'd1);
			5'd17: u = mk_uop(OP_Q2, 1'b1, OP_Q, 1'b1, ACT_MACC, 2'd2);
			5'd18: u = mk_uop(OP_ZERO, 1'b0, OP_ZERO, 1'b0, ACT_ST_Q3, 2'd0);
			5'd20: u = mk_uop(OP_MC, 1'b0, OP_Q3, 1'b0, ACT_MCLR, 2'd0);
			5'd21: u = mk_uop(OP_MC, 1'b0, OP_Q3, 1'b1, ACT_MACC, 2'd1);
			5'd22: u = mk_uop(OP_MC, 1'b1, OP_Q3, 1'b0, ACT_MACC, 2'd1);
			5'd23: u = mk_uop(OP_MC, 1'b1, OP_Q3, 1'b1, ACT_MACC, 2'd2);
			5'd24: u = mk_uop(OP_ZERO, 1'b0, OP_ZERO, 1'b0, ACT_ST_TERM, 2'd0);
			5'd25: u = mk_uop(OP_ZERO, 1'b0, OP_ZERO, 1'b0, ACT_ST_SELF, 2'd0);
			5'd27: u = mk_uop(OP_ZERO, 1'b0, OP_ZERO, 1'b0, ACT_ST_DENS, 2'd0);
			5'd29: u = mk_uop(OP_DIFF, 1'b0, OP_PG, 1'b0, ACT_MCLR, 2'd0);
			5'd30: u = mk_uop(OP_ZERO, 1'b0, OP_ZERO, 1'b0, ACT_ST_PRES, 2'd0);
			default: u = UOP_NOP;
		endcase
		return u;
	endfunction

endpackage

>>> hdl/sphdp_ctrl.sv
// Controller: steps the micro-program for each pair and hands results to the output register.
`timescale 1ns / 1ps

module sphdp_ctrl
	import sphdp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic     out_busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t     state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	logic            self_q, self_d;

	// State, program counter and self-term flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			self_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			self_q  <= self_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		pc_d        = pc_q;
		self_d      = self_q;
		s_tready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.publish = 1'b0;
		cmd.uop     = UOP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					pc_d     = '0;
					self_d   = 1'b0;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.uop = uop_rom(pc_q);
				if (pc_q == PC_TERM) begin
					if (!stat.last) begin
						state_d = ST_IDLE;
					end else if (!self_q) begin
						pc_d = PC_SELF;
					end else begin
						pc_d = PC_DENS;
					end
				end else if (pc_q == PC_SELF_END) begin
					pc_d   = PC_KERNEL;
					self_d = 1'b1;
				end else if (pc_q == PC_LAST) begin
					state_d = ST_PUBLISH;
				end else begin
					pc_d = pc_q + PC_W'(1);
				end
			end
			ST_PUBLISH: begin
				if (!out_busy) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/sphdp_datapath.sv
// Datapath: input differences, shared two-stage digit multiplier, accumulator and result registers.
`timescale 1ns / 1ps

module sphdp_datapath
	import sphdp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	input  logic signed [POS_W-1:0]   center_x,
	input  logic signed [POS_W-1:0]   center_y,
	input  logic signed [POS_W-1:0]   center_z,
	input  logic signed [POS_W-1:0]   neighbor_x,
	input  logic signed [POS_W-1:0]   neighbor_y,
	input  logic signed [POS_W-1:0]   neighbor_z,
	input  logic                      last_neighbor,
	input  logic [MASS_W-1:0]         particle_mass,
	input  logic [H2_W-1:0]           radius_squared,
	input  logic [COEF_W-1:0]         kernel_coefficient,
	input  logic [REST_W-1:0]         rest_dens,
	input  logic [GAIN_W-1:0]         pressure_gain,
	output dp_stat_t                  stat,
	output logic [DENS_W-1:0]         density,
	output logic [PRES_W-1:0]         pressure
);

	logic [ABS_W-1:0]  ax_q, ay_q, az_q;
	logic              last_q;
	logic              active_q;
	logic [CNT_W-1:0]  count_q;
	logic [HQ_W-1:0]   q_q;
	logic [Q2_W-1:0]   q2_q;
	logic [Q3_W-1:0]   q3_q;
	logic [MC_W-1:0]   mc_q;
	logic              keep_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DENS_W-1:0] dens_q;
	logic [DENS_W-1:0] diff_q;
	logic [PRES_W-1:0] pres_q;
	logic [ACC_W-1:0]  acc_q;

	logic [PROD_W-1:0] p_s1;
	act_t              act_s1;
	logic [1:0]        sh_s1;

	logic [HQ_W-1:0]   hq;
	logic [OPV_W-1:0]  a_val, b_val;
	logic [DIG_W-1:0]  a_dig, b_dig;
	logic [ACC_W-1:0]  p_shift;
	logic [ACC_W-1:0]  acc_sum;
	logic [R2_W-1:0]   r2;
	logic [SUM_W-1:0]  term;
	logic [SUM_W:0]    sum_add;
	logic [SUM_W-1:0]  dens_floor;
	logic [SUM_W-1:0]  dens_wide;
	logic [DENS_W-1:0] dens_sat;

	// Absolute difference of one axis, exact in 25 bits
	function automatic logic [ABS_W-1:0] abs_diff(logic signed [POS_W-1:0] c,
		logic signed [POS_W-1:0] n);
		logic signed [ABS_W-1:0] d;
		d = ABS_W'(n) - ABS_W'(c);
		return d[ABS_W-1] ? ABS_W'(-d) : ABS_W'(d);
	endfunction

	// Operand source selection, zero extended to two digits
	function automatic logic [OPV_W-1:0] opnd_val(opnd_t sel, logic [MASS_W-1:0] pm,
		logic [COEF_W-1:0] kc, logic [ABS_W-1:0] ax, logic [ABS_W-1:0] ay,
		logic [ABS_W-1:0] az, logic [HQ_W-1:0] q, logic [Q2_W-1:0] q2,
		logic [Q3_W-1:0] q3, logic [MC_W-1:0] mc, logic [DENS_W-1:0] df,
		logic [GAIN_W-1:0] pg);
		logic [OPV_W-1:0] v;
		v = '0;
		case (sel)
			OP_PM:   v = OPV_W'(pm);
			OP_KC:   v = OPV_W'(kc);
			OP_AX:   v = OPV_W'(ax);
			OP_AY:   v = OPV_W'(ay);
			OP_AZ:   v = OPV_W'(az);
			OP_Q:    v = OPV_W'(q);
			OP_Q2:   v = OPV_W'(q2);
			OP_Q3:   v = OPV_W'(q3);
			OP_MC:   v = OPV_W'(mc);
			OP_DIFF: v = OPV_W'(df);
			OP_PG:   v = OPV_W'(pg);
			default: v = '0;
		endcase
		return v;
	endfunction

	assign hq = {radius_squared, 16'b0};

	// First stage: pick the operand digits and multiply
	always_comb begin
		a_val = opnd_val(cmd.uop.a_sel, particle_mass, kernel_coefficient, ax_q, ay_q, az_q,
			q_q, q2_q, q3_q, mc_q, diff_q, pressure_gain);
		b_val = opnd_val(cmd.uop.b_sel, particle_mass, kernel_coefficient, ax_q, ay_q, az_q,
			q_q, q2_q, q3_q, mc_q, diff_q, pressure_gain);
		a_dig = cmd.uop.a_dig ? a_val[OPV_W-1:DIG_W] : a_val[DIG_W-1:0];
		b_dig = cmd.uop.b_dig ? b_val[OPV_W-1:DIG_W] : b_val[DIG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= ACT_NOP;
		end else begin
			act_s1 <= cmd.uop.act;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= PROD_W'(a_dig) * PROD_W'(b_dig);
		sh_s1 <= cmd.uop.sh;
	end

	// Second stage: place the partial product by its digit weight
	always_comb begin
		case (sh_s1)
			2'd0:    p_shift = {{(ACC_W-PROD_W){1'b0}}, p_s1};
			2'd1:    p_shift = {{(ACC_W-PROD_W-DIG_W){1'b0}}, p_s1, {DIG_W{1'b0}}};
			2'd2:    p_shift = {p_s1, {(ACC_W-PROD_W){1'b0}}};
			default: p_shift = '0;
		endcase
		acc_sum = ((act_s1 == ACT_MCLR) ? '0 : acc_q) + p_shift;
	end

	// Values taken from the accumulator and the running sum
	always_comb begin
		r2         = acc_q[R2_W-1:0];
		term       = (|acc_q[ACC_W-1:ACC_W-8]) ? {SUM_W{1'b1}}
			: acc_q[ACC_W-9:OPV_W];
		sum_add    = {1'b0, sum_q} + {1'b0, term};
		dens_floor = SUM_W'(rest_dens[REST_W-1:1]);
		dens_wide  = (sum_q < dens_floor) ? dens_floor : sum_q;
		dens_sat   = (|dens_wide[SUM_W-1:DENS_W]) ? {DENS_W{1'b1}}
			: dens_wide[DENS_W-1:0];
	end

	// Input capture and neighbour count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			active_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (cmd.load) begin
			active_q <= (count_q < CNT_W'(MAX_NEIGHBORS));
			if (count_q < CNT_W'(MAX_NEIGHBORS)) begin
				count_q <= count_q + CNT_W'(1);
			end
			last_q <= last_neighbor;
		end else if (cmd.publish) begin
			count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= abs_diff(center_x, neighbor_x);
			ay_q <= abs_diff(center_y, neighbor_y);
			az_q <= abs_diff(center_z, neighbor_z);
		end
	end

	// Accumulator and the stores of the second stage
	always_ff @(posedge clk) begin
		case (act_s1)
			ACT_MCLR, ACT_MACC: acc_q <= acc_sum;
			ACT_ST_MC:          mc_q <= acc_q[MC_W-1:0];
			ACT_ST_R2:          q_q <= hq - r2[HQ_W-1:0];
			ACT_ST_Q2:          q2_q <= acc_q[Q2_W+31:32];
			ACT_ST_Q3:          q3_q <= acc_q[Q3_W+31:32];
			ACT_ST_SELF:        q_q <= hq;
			ACT_ST_DENS: begin
				dens_q <= dens_sat;
				diff_q <= (dens_sat > rest_dens) ? dens_sat - rest_dens : '0;
			end
			ACT_ST_PRES: begin
				pres_q <= (|acc_q[47:40]) ? {PRES_W{1'b1}} : acc_q[39:8];
			end
			default: ;
		endcase
	end

	// Pair qualification and the density sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
			sum_q  <= '0;
		end else begin
			if (act_s1 == ACT_ST_R2) begin
				keep_q <= active_q && (r2 != '0) && (r2 < R2_W'(hq));
			end else if (act_s1 == ACT_ST_SELF) begin
				keep_q <= 1'b1;
			end
			if (cmd.publish) begin
				sum_q <= '0;
			end else if (act_s1 == ACT_ST_TERM && keep_q) begin
				sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
			end
		end
	end

	assign stat.last = last_q;
	assign density   = dens_q;
	assign pressure  = pres_q;

endmodule

>>> hdl/sph_density_pressure.sv
// Top level of the SPH poly6 density and pressure unit: configuration, output register, wiring.
//
//  Channel   Direction  Width  Contents (lowest bits first)
//  s_*       in         144+1  center_x, center_y, center_z, neighbor_x, neighbor_y,
//                              neighbor_z; tlast = last_neighbor
//  m_*       out        56     density, pressure
//  cfg_*     in         32     index 0..4: mass, radius squared, coefficient, rest, gain
//
// One pair at a time: a new pair is accepted only once the previous one has run through the
// micro-program, and a last pair also waits for the output register; the pace is set by the
// single 28x28 multiplier that works through each wide product digit by digit.
// Reset clears the controller, the density sum, the neighbour count and the output valid.
// A finished result waits in the output register; the next pair is accepted meanwhile, and
// only a further last pair waits until that register is free.
`timescale 1ns / 1ps

module sph_density_pressure
	import sphdp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// center_x, center_y, center_z, neighbor_x, neighbor_y, neighbor_z
	input  logic [143:0]     s_tdata,
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	// density, pressure
	output logic [55:0]      m_tdata
);

	logic [MASS_W-1:0] mass_q;
	logic [H2_W-1:0]   h2_q;
	logic [COEF_W-1:0] coef_q;
	logic [REST_W-1:0] rest_q;
	logic [GAIN_W-1:0] gain_q;

	logic              out_valid_q;
	logic [DENS_W-1:0] out_dens_q;
	logic [PRES_W-1:0] out_pres_q;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [DENS_W-1:0] dp_dens;
	logic [PRES_W-1:0] dp_pres;
	logic              out_busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MASS_W'(65536);
			h2_q   <= H2_W'(13271);
			coef_q <= COEF_W'(135692288);
			rest_q <= REST_W'(256000);
			gain_q <= GAIN_W'(128000);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MASS: mass_q <= cfg_data[MASS_W-1:0];
				CFG_H2:   h2_q   <= cfg_data[H2_W-1:0];
				CFG_COEF: coef_q <= cfg_data[COEF_W-1:0];
				CFG_REST: rest_q <= cfg_data[REST_W-1:0];
				CFG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Output register, loaded when the controller publishes a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_dens_q <= dp_dens;
			out_pres_q <= dp_pres;
		end
	end

	assign out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_pres_q, out_dens_q};

	sphdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.out_busy (out_busy),
		.stat     (stat),
		.cmd      (cmd)
	);

	sphdp_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.center_x           ($signed(s_tdata[23:0])),
		.center_y           ($signed(s_tdata[47:24])),
		.center_z           ($signed(s_tdata[71:48])),
		.neighbor_x         ($signed(s_tdata[95:72])),
		.neighbor_y         ($signed(s_tdata[119:96])),
		.neighbor_z         ($signed(s_tdata[143:120])),
		.last_neighbor      (s_tlast),
		.particle_mass      (mass_q),
		.radius_squared     (h2_q),
		.kernel_coefficient (coef_q),
		.rest_dens          (rest_q),
		.pressure_gain      (gain_q),
		.stat               (stat),
		.density            (dp_dens),
		.pressure           (dp_pres)
	);

endmodule

>>> tb/sph_density_checker.sv
// Checker for the SPH density and pressure unit: predicts each result and compares it.
`timescale 1ns / 1ps

module sph_density_checker
	import sphdp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [143:0]       s_tdata,
	input  logic               s_tlast,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [55:0]        m_tdata,
	output int unsigned        mismatch_count,
	output int unsigned        results_due
);

	localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(65536);
	localparam logic [H2_W-1:0]   H2_RESET   = H2_W'(13271);
	localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(135692288);
	localparam logic [REST_W-1:0] REST_RESET = REST_W'(256000);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(128000);
	localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
	localparam int unsigned       REPORT_MAX = 10;

	typedef struct packed {
		logic [DENS_W-1:0] density;
		logic [PRES_W-1:0] pressure;
	} dens_pres_t;

	// Register copies and the running sum of the open group
	logic [MASS_W-1:0] mass_q;
	logic [H2_W-1:0]   h2_q;
	logic [COEF_W-1:0] coef_q;
	logic [REST_W-1:0] rest_q;
	logic [GAIN_W-1:0] gain_q;
	logic [SUM_W-1:0]  density_sum;
	int unsigned       group_pairs;
	int unsigned       faults;
	dens_pres_t        density_results_due[$];

	// Square of the distance along one axis, exact.
	function automatic logic [127:0] axis_square(logic [POS_W-1:0] c, logic [POS_W-1:0] n);
		logic signed [POS_W+1:0] d;
		d = $signed({{2{n[POS_W-1]}}, n}) - $signed({{2{c[POS_W-1]}}, c});
		if (d < 0)
			d = -d;
		return 128'($unsigned(d)) * 128'($unsigned(d));
	endfunction

	// Poly6 contribution mass * coefficient * q^3, q in Q.32, result in Q.8.
	function automatic logic [SUM_W-1:0] poly6_term(logic [63:0] q, logic [MASS_W-1:0] m,
		logic [COEF_W-1:0] k);
		logic [127:0] q2;
		logic [127:0] q3;
		logic [127:0] prod;
		q2 = (128'(q) * 128'(q)) >> 32;
		q3 = (q2 * 128'(q)) >> 32;
		prod = ((128'(m) * 128'(k)) * q3) >> 56;
		return (prod > 128'(SUM_MAX)) ? SUM_MAX : prod[SUM_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] sum_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	task automatic log_fault(string text);
		faults++;
		if (faults <= REPORT_MAX)
			$display("density check: %s", text);
	endtask

	always @(posedge clk or negedge arst_n) begin
		dens_pres_t      want;
		logic [63:0]     h;
		logic [127:0]    r2;
		logic [SUM_W-1:0] dens;
		logic [63:0]     pres;
		logic [DENS_W-1:0] got_dens;
		logic [PRES_W-1:0] got_pres;
		if (!arst_n) begin
			mass_q = MASS_RESET;
			h2_q = H2_RESET;
			coef_q = COEF_RESET;
			rest_q = REST_RESET;
			gain_q = GAIN_RESET;
			density_sum = '0;
			group_pairs = 0;
			faults = 0;
			density_results_due.delete();
			mismatch_count <= 0;
			results_due <= 0;
		end else begin
			// Register writes
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MASS: mass_q = cfg_data[MASS_W-1:0];
					CFG_H2:   h2_q = cfg_data[H2_W-1:0];
					CFG_COEF: coef_q = cfg_data[COEF_W-1:0];
					CFG_REST: rest_q = cfg_data[REST_W-1:0];
					CFG_GAIN: gain_q = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end

			// Accepted pair: accumulate, and close the group on the last flag
			if (s_tvalid && s_tready) begin
				h = 64'(h2_q) << 16;
				if (group_pairs < MAX_NEIGHBORS) begin
					r2 = axis_square(s_tdata[0 +: POS_W], s_tdata[72 +: POS_W]) +
						axis_square(s_tdata[24 +: POS_W], s_tdata[96 +: POS_W]) +
						axis_square(s_tdata[48 +: POS_W], s_tdata[120 +: POS_W]);
					if (r2 != 0 && r2 < 128'(h))
						density_sum = sum_add(density_sum,
							poly6_term(h - r2[63:0], mass_q, coef_q));
					group_pairs++;
				end
				if (s_tlast) begin
					density_sum = sum_add(density_sum, poly6_term(h, mass_q, coef_q));
					dens = (density_sum < SUM_W'(rest_q >> 1)) ? SUM_W'(rest_q >> 1) : density_sum;
					if (dens > SUM_W'({DENS_W{1'b1}}))
						dens = SUM_W'({DENS_W{1'b1}});
					pres = 0;
					if (dens > SUM_W'(rest_q)) begin
						pres = (64'(gain_q) * 64'(dens - SUM_W'(rest_q))) >> 8;
						if (pres > 64'({PRES_W{1'b1}}))
							pres = 64'({PRES_W{1'b1}});
					end
					want.density = dens[DENS_W-1:0];
					want.pressure = pres[PRES_W-1:0];
					density_results_due = {density_results_due, want};
					density_sum = '0;
					group_pairs = 0;
				end
			end

			// Delivered result: compare with the oldest prediction
			if (m_tvalid && m_tready) begin
				got_dens = m_tdata[0 +: DENS_W];
				got_pres = m_tdata[DENS_W +: PRES_W];
				if (density_results_due.size() == 0) begin
					log_fault($sformatf("result density %0d pressure %0d with none due",
						got_dens, got_pres));
				end else begin
					want = density_results_due.pop_front();
					if (got_dens !== want.density)
						log_fault($sformatf("density expected %0d got %0d",
							want.density, got_dens));
					if (got_pres !== want.pressure)
						log_fault($sformatf("pressure expected %0d got %0d",
							want.pressure, got_pres));
				end
			end

			mismatch_count <= faults;
			results_due <= density_results_due.size();
		end
	end

endmodule

>>> tb/sph_density_pressure_tb.sv
// Testbench top for the SPH density and pressure unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sph_density_pressure_tb;
	import sphdp_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned HOLD_AT      = 600;
	localparam int unsigned HOLD_CYCLES  = 600;
	localparam int unsigned CALM_FROM    = 800;
	localparam int unsigned CALM_TO      = 1000;
	localparam int unsigned IDLE_PCT     = 8;
	localparam int unsigned PHASES       = 10;
	localparam int unsigned PHASE_PAIRS  = 105;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;
	int unsigned  mismatch_count;
	int unsigned  results_due;
	int unsigned  pairs_sent;
	logic [H2_W-1:0] cur_h2;
	logic         calm;

	sph_density_pressure DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	sph_density_checker density_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Neither side idles inside this window of items.
	assign calm = (pairs_sent >= CALM_FROM) && (pairs_sent < CALM_TO);

	// Offer one pair, with an occasional gap first, and wait for its acceptance.
	task automatic send_pair(input logic [23:0] cx, input logic [23:0] cy, input logic [23:0] cz,
		input logic [23:0] nx, input logic [23:0] ny, input logic [23:0] nz, input logic last);
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {nz, ny, nx, cz, cy, cx};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pairs_sent++;
	endtask

	// Stop offering and let every outstanding result and any pair in flight finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (results_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [31:0] mass, input logic [31:0] h2,
		input logic [31:0] coef, input logic [31:0] rest, input logic [31:0] gain);
		settle();
		write_reg(CFG_MASS, mass);
		write_reg(CFG_H2, h2);
		write_reg(CFG_COEF, coef);
		write_reg(CFG_REST, rest);
		write_reg(CFG_GAIN, gain);
		cfg_we <= 1'b0;
		cur_h2 = h2[H2_W-1:0];
	endtask

	// Register value spread over magnitudes, with zero and full scale now and then.
	function automatic logic [31:0] pick_value(input int unsigned width);
		logic [63:0] mask;
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'((64'd1 << width) - 1);
			default: begin
				mask = (64'd1 << $urandom_range(1, width)) - 1;
				return 32'({$urandom, $urandom} & mask);
			end
		endcase
	endfunction

	// Smoothing radius in position units, rounded up.
	function automatic int reach();
		real r;
		r = $sqrt(real'(cur_h2) * 65536.0);
		return int'(r) + 1;
	endfunction

	// Position moved by an offset, held inside the field's range.
	function automatic logic [23:0] shift_pos(input logic [23:0] p, input int off);
		int v;
		v = int'($signed(p)) + off;
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return 24'(v);
	endfunction

	// One centre, now and then moved, with a random number of neighbours, mostly near, some noise.
	task automatic random_group();
		int unsigned n;
		int unsigned sel;
		int hr;
		logic [23:0] cx, cy, cz, nx, ny, nz;
		sel = $urandom_range(0, 99);
		n = (sel < 70) ? $urandom_range(1, 6) : (sel < 95) ? $urandom_range(7, 20) :
			$urandom_range(21, 60);
		hr = reach();
		cx = $urandom;
		cy = $urandom;
		cz = $urandom;
		for (int unsigned i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				cx = $urandom;
				cy = $urandom;
				cz = $urandom;
			end
			if (sel >= 5 && sel < 15) begin
				nx = cx;
				ny = cy;
				nz = cz;
			end else if (sel >= 15 && sel < 25) begin
				nx = $urandom;
				ny = $urandom;
				nz = $urandom;
			end else begin
				nx = shift_pos(cx, int'($urandom_range(0, 2 * hr)) - hr);
				ny = shift_pos(cy, int'($urandom_range(0, 2 * hr)) - hr);
				nz = shift_pos(cz, int'($urandom_range(0, 2 * hr)) - hr);
			end
			send_pair(cx, cy, cz, nx, ny, nz, i == n - 1);
		end
	endtask

	// Receiver: random stalls, one long hold-off, and a calm stretch.
	initial begin
		logic held;
		held = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && pairs_sent >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Main sequence
	initial begin
		int unsigned start;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MASS;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		pairs_sent = 0;
		cur_h2 = H2_W'(13271);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs with the reset settings: coincident, inside, outside, extremes.
		send_pair(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
		send_pair(24'd0, 24'd0, 24'd0, 24'h001000, 24'd0, 24'd0, 1'b0);
		send_pair(24'd0, 24'd0, 24'd0, 24'd0, 24'h008000, 24'd0, 1'b0);
		send_pair(24'd0, 24'd0, 24'd0, -24'sh2000, 24'h001000, -24'sh3000, 1'b1);
		send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000, 1'b1);
		send_pair(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
		// The centre moves within one group.
		send_pair(24'd100, 24'd200, 24'd300, 24'd100, 24'd200, 24'd1300, 1'b0);
		send_pair(-24'sd5000, 24'd7, 24'd9, -24'sd4000, 24'd2007, 24'd9, 1'b1);

		// Radius of exactly one metre: a pair on the boundary and two just inside.
		apply_setting(32'd65536, 32'd65536, 32'd135692288, 32'd256000, 32'd128000);
		send_pair(24'd0, 24'd0, 24'd0, 24'd65536, 24'd0, 24'd0, 1'b0);
		send_pair(24'd0, 24'd0, 24'd0, 24'd65535, 24'd0, 24'd0, 1'b0);
		send_pair(24'd0, 24'd0, 24'd0, 24'd0, -24'sd65535, 24'd0, 1'b1);

		// Registers change while a group is open.
		send_pair(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h004000, 1'b0);
		apply_setting(32'd4194304, 32'd65536, 32'd135692288, 32'd256000, 32'd2000000);
		send_pair(24'd0, 24'd0, 24'd0, 24'h002000, 24'd0, 24'd0, 1'b1);

		// Random groups over several register settings, extremes first.
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_setting(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF, 32'd0, 32'hFFFFFF);
				1: apply_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
				2: apply_setting(32'd65536, 32'd13271, 32'd135692288, 32'd256000, 32'd128000);
				3: apply_setting(pick_value(MASS_W), pick_value(H2_W), pick_value(COEF_W),
					32'hFFFFFF, pick_value(GAIN_W));
				default: apply_setting(pick_value(MASS_W), pick_value(H2_W), pick_value(COEF_W),
					pick_value(REST_W), pick_value(GAIN_W));
			endcase
			start = pairs_sent;
			while (pairs_sent - start < PHASE_PAIRS)
				random_group();
		end

		settle();
		if (mismatch_count == 0 && results_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Overall time limit
	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
